// ----- rtl/c1d_pkg.sv -----
// Shared types and constants of the 1D convolution stream block.
// No dependencies; imported by c1d_cell, the top level and the testbench.
package c1d_pkg;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_INIT,
        OP_MAC,
        OP_FIN
    } t_op;

    typedef struct packed {
        logic signed [23:0] value;
        logic               sat;
    } t_res;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_WEIGHT = 2'd1;
    localparam logic [1:0] KIND_BIAS   = 2'd2;

    localparam logic [2:0] CFG_IN_CH   = 3'd0;
    localparam logic [2:0] CFG_OUT_CH  = 3'd1;
    localparam logic [2:0] CFG_KSIZE   = 3'd2;
    localparam logic [2:0] CFG_STRIDE  = 3'd3;
    localparam logic [2:0] CFG_PAD     = 3'd4;
    localparam logic [2:0] CFG_SEQ_LEN = 3'd5;

    localparam int RES_MAX    = 64;
    localparam int STRIDE_MAX = 8;

    // address width of a store with n entries, at least one bit
    function automatic int addr_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

// ----- rtl/c1d_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module c1d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/c1d_cell.sv -----
// One output-channel cell: local weight RAM, bias, MAC and result hold.
// Depends on c1d_pkg and c1d_ram.
module c1d_cell import c1d_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_op                      i_op,
    input  logic [addr_w(DEPTH)-1:0] i_waddr,
    input  logic signed [15:0]       i_sample,
    output t_op                      o_op,
    output logic [addr_w(DEPTH)-1:0] o_waddr,
    output logic signed [15:0]       o_sample,
    input  logic                     i_w_we,
    input  logic [addr_w(DEPTH)-1:0] i_w_addr,
    input  logic signed [15:0]       i_w_data,
    input  logic                     i_b_we,
    input  logic signed [15:0]       i_b_data,
    input  logic                     i_shift,
    input  t_res                     i_next,
    output t_res                     o_hold
);
    localparam int AW = addr_w(DEPTH);

    t_op                r_op_o, r_op_b, r_op_c;
    logic [AW-1:0]      r_waddr_o;
    logic signed [15:0] r_samp, r_bias;
    logic signed [31:0] r_prod;
    logic signed [39:0] r_acc;
    t_res               r_hold;
    logic [15:0]        w_raw;
    logic signed [39:0] n_sum, n_q;
    t_res               n_res;

    c1d_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_wram (
        .i_clk   (i_clk),
        .i_we    (i_w_we),
        .i_waddr (i_w_addr),
        .i_wdata (i_w_data),
        .i_raddr (i_waddr),
        .o_rdata (w_raw)
    );

    // round half up from Q.14 to an integer, saturate to 24 bits
    always_comb begin
        n_sum = r_acc + 40'sd8192;
        n_q   = n_sum >>> 14;
        n_res.sat = 1'b0;
        n_res.value = n_q[23:0];
        if (n_q > 40'sd8388607) begin
            n_res.value = 24'sh7FFFFF;
            n_res.sat = 1'b1;
        end else if (n_q < -40'sd8388608) begin
            n_res.value = 24'sh800000;
            n_res.sat = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_o <= OP_NONE;
            r_op_b <= OP_NONE;
            r_op_c <= OP_NONE;
            r_bias <= '0;
        end else begin
            r_op_o <= i_op;
            r_op_b <= i_op;
            r_op_c <= r_op_b;
            if (i_b_we) begin
                r_bias <= i_b_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_waddr_o <= i_waddr;
        r_samp    <= i_sample;
        r_prod    <= $signed(w_raw) * i_sample;
        case (r_op_c)
            OP_INIT: r_acc <= {{10{r_bias[15]}}, r_bias, 14'd0};
            OP_MAC:  r_acc <= r_acc + {{8{r_prod[31]}}, r_prod};
            OP_FIN:  r_hold <= n_res;
            default: ;
        endcase
        if (i_shift) begin
            r_hold <= i_next;
        end
    end

    assign o_op     = r_op_o;
    assign o_waddr  = r_waddr_o;
    assign o_sample = r_samp;
    assign o_hold   = r_hold;
endmodule

// ----- rtl/conv1d_forward_stream.sv -----
// Top level of the streaming multichannel 1D convolution block.
// Depends on c1d_pkg, c1d_ram and c1d_cell.
//
// Usage:
//  - Input channel (i_in_valid / o_in_stall): one item per handshake; kind selects
//    sample, weight write or bias write.
//  - Samples arrive time-major, C items per time step (C = input channel count).
//    Samples that do not close a step are taken back to back. A closing step
//    stalls the input: a check, then per emitted position an init, one issue per
//    tap and channel, a finish, a drain down the cell chain, one emit per output
//    channel and one more check.
//    A closing step that emits nothing stalls the input only for the check.
//  - The first result item of a position waits on the single shared tap sequencer
//    feeding the chain (one tap and channel per cycle) and on the chain depth.
//  - Output channel (o_out_valid / i_out_stall): one result item per handshake,
//    time-major, one item per output channel and position; last marks the final
//    item of an input item, end_of_sequence the final item of a sequence.
//  - A stalled output holds its item; the sequencer waits, nothing is lost.
//  - Configuration port: always ready; a write to a known register abandons
//    the sequence in progress. Writes are expected only while idle.
//  - Reset (synchronous, active low) restores register defaults, zero biases
//    and an empty sequence. Weights are undefined until written.
module conv1d_forward_stream import c1d_pkg::*; #(
    parameter int IN_CH_MAX  = 8,
    parameter int OUT_CH_MAX = 8,
    parameter int K_MAX      = 8,
    parameter int SEQ_MAX    = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_kind,
    input  logic signed [15:0] i_value,
    input  logic [2:0]         i_out_index,
    input  logic [2:0]         i_in_index,
    input  logic [2:0]         i_tap_index,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_out_channel,
    output logic [12:0]        o_position,
    output logic signed [23:0] o_result_value,
    output logic               o_saturated,
    output logic               o_last,
    output logic               o_end_of_sequence,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [12:0]        i_cfg_data
);
    localparam int WDEPTH = IN_CH_MAX * K_MAX;
    localparam int WAW    = addr_w(WDEPTH);
    localparam int SAW    = addr_w(WDEPTH);
    localparam int KW     = addr_w(K_MAX);
    localparam int DW     = $clog2(OUT_CH_MAX + 2);

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_INIT, S_MAC, S_FIN, S_DRAIN, S_EMIT
    } t_state;

    function automatic logic [3:0] eff4(input logic [3:0] raw, input int hi);
        if (raw == 4'd0) return 4'd1;
        return (32'(raw) > hi) ? 4'(hi) : raw;
    endfunction

    t_state        r_state;
    logic [3:0]    r_in_ch, r_out_ch, r_ks, r_st;
    logic [2:0]    r_pad;
    logic [12:0]   r_sl;
    logic [12:0]   r_psc, r_pos;
    logic [3:0]    r_cc, r_k, r_c, r_e;
    logic [KW-1:0] r_slot;
    logic [15:0]   r_start, r_avail, r_newest;
    logic          r_end, r_last_pos;
    logic [7:0]    r_n;
    logic [DW-1:0] r_drain;
    logic          r_ovalid, r_olast, r_oeos;
    logic [2:0]    r_och;
    logic [12:0]   r_opos;
    t_res          r_ores;

    logic [3:0]    ic, oc, ks, st;
    logic [12:0]   sl;
    logic [15:0]   padsl, tap_t, tap_r;
    logic [12:0]   psc_inc;
    logic [3:0]    cc_eff;
    logic          new_step, in_acc, cfg_acc, tap_ok, elig, more, out_free, shift;
    logic [KW-1:0] slot_w, slot_r;
    logic [SAW-1:0] s_waddr, s_raddr;
    logic [WAW-1:0] tok_waddr, w_waddr;
    logic [15:0]   s_rdata;
    logic          w_ok;

    t_op                op_c   [OUT_CH_MAX+1];
    logic [WAW-1:0]     wa_c   [OUT_CH_MAX+1];
    logic signed [15:0] smp_c  [OUT_CH_MAX+1];
    t_res               hold_c [OUT_CH_MAX];

    assign ic = eff4(r_in_ch, IN_CH_MAX);
    assign oc = eff4(r_out_ch, OUT_CH_MAX);
    assign ks = eff4(r_ks, K_MAX);
    assign st = eff4(r_st, STRIDE_MAX);
    assign sl = (r_sl == 13'd0) ? 13'd1 : ((32'(r_sl) > SEQ_MAX) ? 13'(SEQ_MAX) : r_sl);

    assign padsl    = 16'(r_pad) + 16'(sl);
    assign in_acc   = i_in_valid && !o_in_stall;
    assign cfg_acc  = i_cfg_valid && o_cfg_ready;
    assign out_free = !r_ovalid || !i_out_stall;
    assign shift    = (r_state == S_EMIT) && out_free;

    // sample write side: ring of K_MAX step slots
    always_comb begin
        cc_eff   = (r_cc >= ic) ? 4'd0 : r_cc;
        new_step = (cc_eff == 4'd0);
        if (new_step) begin
            slot_w = (32'(r_slot) == K_MAX - 1) ? '0 : KW'(32'(r_slot) + 1);
        end else begin
            slot_w = r_slot;
        end
        s_waddr = SAW'(32'(slot_w) * IN_CH_MAX + 32'(cc_eff));
        psc_inc = r_psc + 13'd1;
    end

    // tap read side: padded step of this tap and its distance to the newest step
    always_comb begin
        tap_t  = r_start + 16'(r_k);
        tap_r  = r_newest - tap_t;
        tap_ok = (tap_t >= 16'(r_pad)) && (tap_t < padsl) && (tap_t <= r_newest)
                 && (32'(tap_r) < K_MAX);
        if (32'(r_slot) >= 32'(tap_r)) begin
            slot_r = KW'(32'(r_slot) - 32'(tap_r));
        end else begin
            slot_r = KW'(32'(r_slot) + K_MAX - 32'(tap_r));
        end
        s_raddr   = SAW'(32'(slot_r) * IN_CH_MAX + 32'(r_c));
        tok_waddr = WAW'(32'(r_c) * K_MAX + 32'(r_k));
        case (r_state)
            S_INIT:  op_c[0] = OP_INIT;
            S_MAC:   op_c[0] = tap_ok ? OP_MAC : OP_NONE;
            S_FIN:   op_c[0] = OP_FIN;
            default: op_c[0] = OP_NONE;
        endcase
        elig = (r_start + 16'(ks) <= r_avail) && (r_n + 8'(oc) <= 8'(RES_MAX));
        more = (r_start + 16'(st) + 16'(ks) <= r_avail)
               && (r_n + 8'(oc) + 8'(oc) <= 8'(RES_MAX));
    end

    assign wa_c[0]  = tok_waddr;
    assign smp_c[0] = $signed(s_rdata);

    assign w_ok = in_acc && (i_kind == KIND_WEIGHT) && (32'(i_out_index) < OUT_CH_MAX)
                  && (32'(i_in_index) < IN_CH_MAX) && (32'(i_tap_index) < K_MAX);
    assign w_waddr = WAW'(32'(i_in_index) * K_MAX + 32'(i_tap_index));

    c1d_ram #(.WIDTH(16), .DEPTH(WDEPTH)) u_window (
        .i_clk   (i_clk),
        .i_we    (in_acc && (i_kind == KIND_SAMPLE)),
        .i_waddr (s_waddr),
        .i_wdata (i_value),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    // chain of output-channel cells: taps travel up, results travel down
    for (genvar g = 0; g < OUT_CH_MAX; g++) begin : g_cell
        t_res nxt;
        if (g == OUT_CH_MAX - 1) begin : g_top
            assign nxt = '0;
        end else begin : g_mid
            assign nxt = hold_c[g+1];
        end
        c1d_cell #(.DEPTH(WDEPTH)) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_op     (op_c[g]),
            .i_waddr  (wa_c[g]),
            .i_sample (smp_c[g]),
            .o_op     (op_c[g+1]),
            .o_waddr  (wa_c[g+1]),
            .o_sample (smp_c[g+1]),
            .i_w_we   (w_ok && (32'(i_out_index) == g)),
            .i_w_addr (w_waddr),
            .i_w_data (i_value),
            .i_b_we   (in_acc && (i_kind == KIND_BIAS) && (32'(i_out_index) == g)),
            .i_b_data (i_value),
            .i_shift  (shift),
            .i_next   (nxt),
            .o_hold   (hold_c[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_in_ch  <= 4'd1;
            r_out_ch <= 4'd1;
            r_ks     <= 4'd3;
            r_st     <= 4'd1;
            r_pad    <= 3'd0;
            r_sl     <= 13'd64;
            r_psc    <= 13'd0;
            r_cc     <= 4'd0;
            r_pos    <= 13'd0;
            r_start  <= 16'd0;
            r_slot   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            if (cfg_acc && (i_cfg_index <= CFG_SEQ_LEN)) begin
                case (i_cfg_index)
                    CFG_IN_CH:  r_in_ch  <= i_cfg_data[3:0];
                    CFG_OUT_CH: r_out_ch <= i_cfg_data[3:0];
                    CFG_KSIZE:  r_ks     <= i_cfg_data[3:0];
                    CFG_STRIDE: r_st     <= i_cfg_data[3:0];
                    CFG_PAD:    r_pad    <= i_cfg_data[2:0];
                    default:    r_sl     <= i_cfg_data;
                endcase
                // abandon the sequence
                r_psc   <= (i_cfg_index == CFG_PAD) ? 13'(i_cfg_data[2:0]) : 13'(r_pad);
                r_cc    <= 4'd0;
                r_pos   <= 13'd0;
                r_start <= 16'd0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc && (i_kind == KIND_SAMPLE)) begin
                        r_slot <= slot_w;
                        if (cc_eff + 4'd1 >= ic) begin
                            r_cc     <= 4'd0;
                            r_psc    <= psc_inc;
                            r_newest <= 16'(r_psc);
                            r_end    <= (16'(psc_inc) >= padsl);
                            r_avail  <= (16'(psc_inc) >= padsl) ? padsl + 16'(r_pad)
                                                                : 16'(psc_inc);
                            r_n      <= 8'd0;
                            r_state  <= S_CHECK;
                        end else begin
                            r_cc <= cc_eff + 4'd1;
                        end
                    end
                end
                S_CHECK: begin
                    if (elig) begin
                        r_last_pos <= !more;
                        r_state    <= S_INIT;
                    end else begin
                        if (r_end) begin
                            r_psc   <= 13'(r_pad);
                            r_cc    <= 4'd0;
                            r_pos   <= 13'd0;
                            r_start <= 16'd0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_INIT: begin
                    r_k     <= 4'd0;
                    r_c     <= 4'd0;
                    r_state <= S_MAC;
                end
                S_MAC: begin
                    if (r_c + 4'd1 >= ic) begin
                        r_c <= 4'd0;
                        r_k <= r_k + 4'd1;
                        if (r_k + 4'd1 >= ks) begin
                            r_state <= S_FIN;
                        end
                    end else begin
                        r_c <= r_c + 4'd1;
                    end
                end
                S_FIN: begin
                    r_drain <= DW'(OUT_CH_MAX + 1);
                    r_state <= S_DRAIN;
                end
                S_DRAIN: begin
                    if (r_drain == '0) begin
                        r_e     <= 4'd0;
                        r_state <= S_EMIT;
                    end else begin
                        r_drain <= r_drain - 1'b1;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_och    <= r_e[2:0];
                        r_opos   <= r_pos;
                        r_ores   <= hold_c[0];
                        r_olast  <= (r_e + 4'd1 >= oc) && r_last_pos;
                        r_oeos   <= (r_e + 4'd1 >= oc) && r_last_pos && r_end;
                        if (r_e + 4'd1 >= oc) begin
                            r_n     <= r_n + 8'(oc);
                            r_pos   <= r_pos + 13'd1;
                            r_start <= r_start + 16'(st);
                            r_state <= S_CHECK;
                        end else begin
                            r_e <= r_e + 4'd1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_cfg_ready       = 1'b1;
    assign o_out_valid       = r_ovalid;
    assign o_out_channel     = r_och;
    assign o_position        = r_opos;
    assign o_result_value    = r_ores.value;
    assign o_saturated       = r_ores.sat;
    assign o_last            = r_olast;
    assign o_end_of_sequence = r_oeos;
endmodule

// ----- verif/tb_conv1d_forward_stream.sv -----
// Self-checking testbench of conv1d_forward_stream: random and directed items,
// scored against a fixed-point convolution predictor. Depends on c1d_pkg and the design under test.
module tb_conv1d_forward_stream;
    import c1d_pkg::*;

    // Predicts the result items of each accepted input item and checks the
    // block's result items against them in order.
    class conv_scoreboard;
        typedef struct {
            bit [2:0]         ch;
            bit [12:0]        pos;
            bit signed [23:0] val;
            bit               sat;
            bit               last;
            bit               eos;
        } conv_res_t;

        conv_res_t   pending_results[$];
        shortint     weights[512];
        shortint     biases[8];
        shortint     window[64];
        int unsigned step_cnt, chan_cnt, next_pos;
        int unsigned reg_val[6];
        int          errors, checked;

        function new();
            foreach (weights[i]) weights[i] = 0;
            foreach (biases[i]) biases[i] = 0;
            reg_val = '{1, 1, 3, 1, 0, 64};
            errors = 0;
            checked = 0;
            clear_seq();
        endfunction

        // register value as the block uses it: zero acts as one, clamp at hi
        function int unsigned eff(int unsigned v, int unsigned hi);
            return (v == 0) ? 1 : ((v > hi) ? hi : v);
        endfunction

        function void clear_seq();
            foreach (window[i]) window[i] = 0;
            step_cnt = reg_val[CFG_PAD];
            chan_cnt = 0;
            next_pos = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [12:0] d);
            case (idx)
                CFG_IN_CH:   reg_val[CFG_IN_CH]   = d[3:0];
                CFG_OUT_CH:  reg_val[CFG_OUT_CH]  = d[3:0];
                CFG_KSIZE:   reg_val[CFG_KSIZE]   = d[3:0];
                CFG_STRIDE:  reg_val[CFG_STRIDE]  = d[3:0];
                CFG_PAD:     reg_val[CFG_PAD]     = d[2:0];
                CFG_SEQ_LEN: reg_val[CFG_SEQ_LEN] = d;
                default: return;
            endcase
            clear_seq();
        endfunction

        function void note_item(logic [1:0] kind, logic signed [15:0] v,
                                logic [2:0] oi, logic [2:0] ii, logic [2:0] ti);
            int unsigned ic, oc, ks, st, sl, pd, total, seq_out, newest, avail;
            int unsigned p, t, r, n;
            bit          done;
            longint      acc;
            conv_res_t   res;
            ic = eff(reg_val[CFG_IN_CH], 8);
            oc = eff(reg_val[CFG_OUT_CH], 8);
            ks = eff(reg_val[CFG_KSIZE], 8);
            st = eff(reg_val[CFG_STRIDE], STRIDE_MAX);
            sl = eff(reg_val[CFG_SEQ_LEN], 4096);
            pd = reg_val[CFG_PAD];
            n = 0;
            if (kind == KIND_WEIGHT) begin
                weights[{oi, ii, ti}] = v;
                return;
            end
            if (kind == KIND_BIAS) begin
                biases[oi] = v;
                return;
            end
            if (kind != KIND_SAMPLE) return;

            if (chan_cnt >= ic) chan_cnt = 0;
            if (chan_cnt == 0) begin
                for (int i = 63; i >= 8; i--) window[i] = window[i-8];
                for (int i = 0; i < 8; i++) window[i] = 0;
            end
            window[chan_cnt] = v;
            chan_cnt++;
            if (chan_cnt < ic) return;
            chan_cnt = 0;

            step_cnt = (step_cnt + 1) & 13'h1fff;
            newest = step_cnt - 1;
            avail = step_cnt;
            done = (step_cnt >= pd + sl);
            if (done) avail = pd + sl + pd;
            total = sl + 2 * pd;
            seq_out = (total < ks) ? 0 : (total - ks) / st + 1;

            p = next_pos;
            while (p < seq_out && p * st + ks - 1 < avail) begin
                if (n + oc > RES_MAX) break;
                for (int o = 0; o < oc; o++) begin
                    acc = longint'(biases[o]) * 16384;
                    for (int k = 0; k < ks; k++) begin
                        t = p * st + k;
                        if (t < pd || t >= pd + sl || t > newest) continue;
                        r = newest - t;
                        if (r >= 8) continue;
                        for (int c = 0; c < ic; c++)
                            acc += longint'(window[r*8+c]) * longint'(weights[o*64+c*8+k]);
                    end
                    acc = (acc + 8192) >>> 14;    // round half up, floor shift
                    res.sat = 0;
                    if (acc > 8388607) begin
                        acc = 8388607;
                        res.sat = 1;
                    end else if (acc < -8388608) begin
                        acc = -8388608;
                        res.sat = 1;
                    end
                    res.ch = 3'(o);
                    res.pos = 13'(p);
                    res.val = acc[23:0];
                    res.last = 0;
                    res.eos = 0;
                    pending_results.push_back(res);
                    n++;
                end
                p++;
            end
            next_pos = p & 13'h1fff;
            if (n > 0) begin
                pending_results[pending_results.size()-1].last = 1;
                if (done) pending_results[pending_results.size()-1].eos = 1;
            end
            if (done) clear_seq();
        endfunction

        function void field_cmp(string name, longint e, longint a);
            if (e != a) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
                errors++;
            end
        endfunction

        function void check_result(logic [2:0] ch, logic [12:0] pos,
                                   logic signed [23:0] val, logic sat,
                                   logic last, logic eos);
            conv_res_t e;
            checked++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual ch %0d pos %0d val %0d",
                         $time, ch, pos, val);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            field_cmp("out_channel", e.ch, ch);
            field_cmp("position", e.pos, pos);
            field_cmp("result_value", e.val, val);
            field_cmp("saturated", e.sat, sat);
            field_cmp("last", e.last, last);
            field_cmp("end_of_sequence", e.eos, eos);
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [1:0]         i_kind;
    logic signed [15:0] i_value;
    logic [2:0]         i_out_index;
    logic [2:0]         i_in_index;
    logic [2:0]         i_tap_index;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [2:0]         o_out_channel;
    logic [12:0]        o_position;
    logic signed [23:0] o_result_value;
    logic               o_saturated;
    logic               o_last;
    logic               o_end_of_sequence;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [12:0]        i_cfg_data;

    conv_scoreboard sb;
    bit             weight_set[512];   // weight entries written since reset
    bit             quiet;             // phase without idling on either side
    int             rnd_items;
    int             n_phases;
    int             stall_left;

    conv1d_forward_stream u_top (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard limit on run time, far beyond the slowest legal run.
    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Output side: score each accepted result item, then stall a random
    // number of cycles before taking the next one.
    always @(posedge i_clk) begin
        int nh;
        if (!i_rst_n) begin
            i_out_stall <= 0;
            stall_left <= 0;
        end else begin
            nh = stall_left;
            if (o_out_valid && !i_out_stall) begin
                sb.check_result(o_out_channel, o_position, o_result_value,
                                o_saturated, o_last, o_end_of_sequence);
                nh = quiet ? 0 : $urandom_range(0, 8);
            end
            if (nh > 0) begin
                i_out_stall <= 1;
                stall_left <= nh - 1;
            end else begin
                i_out_stall <= 0;
                stall_left <= 0;
            end
        end
    end

    // One input item: optional idle gap, then hold the item until accepted.
    // With no gap, valid simply stays high into the next item.
    task automatic send_item(logic [1:0] kind, logic [15:0] v,
                             logic [2:0] oi, logic [2:0] ii, logic [2:0] ti);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_kind <= kind;
        i_value <= v;
        i_out_index <= oi;
        i_in_index <= ii;
        i_tap_index <= ti;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_item(kind, v, oi, ii, ti);
        if (kind == KIND_WEIGHT) weight_set[{oi, ii, ti}] = 1;
    endtask

    // Valid stays high between back-to-back writes; the caller drops it.
    task automatic write_reg(logic [2:0] idx, logic [12:0] d);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, d);
    endtask

    // Drain all expected results, then let any result-free work finish.
    task automatic settle();
        i_in_valid <= 0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (2000) @(posedge i_clk);
    endtask

    // Fill every weight the current shape reads that was never written,
    // so no undefined entry is ever used.
    task automatic load_weights();
        int unsigned ic, oc, ks;
        ic = sb.eff(sb.reg_val[CFG_IN_CH], 8);
        oc = sb.eff(sb.reg_val[CFG_OUT_CH], 8);
        ks = sb.eff(sb.reg_val[CFG_KSIZE], 8);
        for (int o = 0; o < oc; o++)
            for (int c = 0; c < ic; c++)
                for (int k = 0; k < ks; k++)
                    if (!weight_set[o*64+c*8+k])
                        send_item(KIND_WEIGHT, $urandom, o, c, k);
    endtask

    task automatic set_config(int a, int b, int c, int d, int e, int f);
        settle();
        write_reg(CFG_IN_CH, a);
        write_reg(CFG_OUT_CH, b);
        write_reg(CFG_KSIZE, c);
        write_reg(CFG_STRIDE, d);
        write_reg(CFG_PAD, e);
        write_reg(CFG_SEQ_LEN, f);
        i_cfg_valid <= 0;
        n_phases++;
        quiet = ($urandom_range(0, 3) == 0);
        load_weights();
    endtask

    // Samples of one sequence (or of the first n_steps steps), with a few
    // weight and bias rewrites and unused-kind items sprinkled in.
    task automatic run_seq(int n_steps);
        int unsigned ic;
        logic [15:0] v;
        ic = sb.eff(sb.reg_val[CFG_IN_CH], 8);
        for (int i = 0; i < n_steps * ic; i++) begin
            case ($urandom_range(0, 19))
                0: begin
                    send_item(KIND_WEIGHT, $urandom, $urandom, $urandom, $urandom);
                    rnd_items++;
                end
                1: begin
                    send_item(KIND_BIAS, $urandom, $urandom, $urandom, $urandom);
                    rnd_items++;
                end
                2: send_item(2'd3, $urandom, $urandom, $urandom, $urandom);
                default: ;
            endcase
            v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) - 128 : $urandom;
            send_item(KIND_SAMPLE, v, $urandom, $urandom, $urandom);
            rnd_items++;
        end
    endtask

    initial begin
        int unsigned sl, ic;
        sb = new();
        rnd_items = 0;
        n_phases = 0;
        quiet = 0;
        i_rst_n = 0;
        i_in_valid = 0;
        i_kind = KIND_SAMPLE;
        i_value = 0;
        i_out_index = 0;
        i_in_index = 0;
        i_tap_index = 0;
        i_out_stall = 0;
        i_cfg_valid = 0;
        i_cfg_index = 0;
        i_cfg_data = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed part on reset settings: field extremes, unused kind,
        // a weight rewrite in the middle of a sequence.
        load_weights();
        send_item(KIND_BIAS, 16'h7fff, 3'd0, 3'd7, 3'd7);
        send_item(KIND_SAMPLE, 16'h7fff, 3'd7, 3'd7, 3'd7);
        send_item(KIND_SAMPLE, 16'h8000, 3'd0, 3'd0, 3'd0);
        send_item(KIND_SAMPLE, 16'h0000, 3'd0, 3'd0, 3'd0);
        send_item(2'd3, 16'hffff, 3'd7, 3'd7, 3'd7);
        send_item(KIND_SAMPLE, 16'hffff, 3'd0, 3'd0, 3'd0);
        send_item(KIND_BIAS, 16'h8000, 3'd0, 3'd0, 3'd0);
        send_item(KIND_WEIGHT, 16'h8000, 3'd0, 3'd0, 3'd2);
        send_item(KIND_SAMPLE, 16'h8000, 3'd0, 3'd0, 3'd0);
        send_item(KIND_SAMPLE, 16'h8000, 3'd0, 3'd0, 3'd0);
        send_item(KIND_WEIGHT, 16'h7fff, 3'd7, 3'd7, 3'd7);
        send_item(KIND_SAMPLE, 16'h0001, 3'd0, 3'd0, 3'd0);

        // zero registers act as one: every sample is a whole sequence
        set_config(0, 0, 0, 0, 0, 0);
        run_seq(3);
        // widest shape, largest pad and stride, one real step
        set_config(15, 15, 15, 15, 7, 1);
        run_seq(2);
        // one step framed by the largest pad: more positions than one burst holds
        set_config(1, 8, 1, 1, 7, 1);
        run_seq(2);
        // sequence shorter than the kernel: no results at all
        set_config(2, 3, 8, 1, 0, 3);
        run_seq(3);
        // longest sequence, left unfinished and abandoned by the next write
        set_config(8, 8, 8, 1, 0, 8191);
        run_seq(3);
        set_config(8, 1, 8, 1, 0, 4096);
        run_seq(2);

        // Random part: mostly whole sequences on random shapes.
        rnd_items = 0;
        while (rnd_items < 210) begin
            sl = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 6);
            set_config($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15),
                       $urandom_range(0, 15), $urandom_range(0, 7), sl);
            ic = sb.eff(sb.reg_val[CFG_IN_CH], 8);
            sl = sb.eff(sb.reg_val[CFG_SEQ_LEN], 4096);
            repeat ($urandom_range(1, 3)) begin
                if (sl * ic > 64) run_seq($urandom_range(1, 64 / ic));
                else if ($urandom_range(0, 7) == 0) run_seq($urandom_range(0, sl));
                else run_seq(sl);
            end
        end

        settle();
        $display("Covered %0d configurations, %0d random items, %0d results checked.",
                 n_phases, rnd_items, sb.checked);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches found.", sb.errors);
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

// ----- files.f -----
rtl/c1d_pkg.sv
rtl/c1d_ram.sv
rtl/c1d_cell.sv
rtl/conv1d_forward_stream.sv
verif/tb_conv1d_forward_stream.sv
